[rtl/core/drrip_pkg.sv]
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared sizes, codes and controller/datapath command types of the DRRIP
// replacement engine.
// ----------------------------------------------------------------------------
package drrip_pkg;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int LEADER_SETS = 64;
    localparam int SEL_W       = 10;
    localparam int RRPV_W      = 2;
    localparam int ADDR_W      = 48;

    localparam int SET_W    = $clog2(SETS);
    localparam int WAY_W    = $clog2(WAYS);
    localparam int STRIDE_W = ADDR_W + 1;
    localparam int DEAD_W   = 2;
    localparam int CONF_W   = 2;
    localparam int SEED_W   = 16;
    localparam int BIM_W    = 5;
    localparam int STRM_W   = 1 + CONF_W + STRIDE_W + ADDR_W;

    localparam logic [RRPV_W-1:0] RRPV_TOP    = '1;
    localparam logic [DEAD_W-1:0] DEAD_FULL   = 2'd3;
    localparam logic [CONF_W-1:0] CONF_TOP    = 2'd3;
    localparam logic [CONF_W-1:0] CONF_STREAM = 2'd2;
    localparam logic [SEL_W-1:0]  SEL_TOP     = '1;
    localparam logic [SEL_W-1:0]  SEL_MID     = SEL_W'(1 << (SEL_W - 1));
    localparam logic [SEED_W-1:0] SEED_RESET  = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS   = 16'hB400;

    localparam logic [1:0] REASON_INVALID = 2'd0;
    localparam logic [1:0] REASON_DEAD    = 2'd1;
    localparam logic [1:0] REASON_RRIP    = 2'd2;

    typedef enum logic [1:0] {
        KIND_QUERY  = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_QUERY  = 2'd1,
        OP_UPDATE = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef struct packed {
        logic             load;
        logic             rd;
        logic             wr_rrpv;
        logic             wr_dead;
        logic             wr_strm;
        logic             sweep;
        t_op              op;
        logic             out_load;
        logic [SET_W-1:0] sweep_addr;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

[rtl/core/drrip_ctrl.sv]
// ----------------------------------------------------------------------------
// drrip_ctrl
// Sequencer: reset clearing sweep, query and update read-modify-write, and
// the dead-counter decay sweep.
// ----------------------------------------------------------------------------
module drrip_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_kind,
    output logic              o_ready,
    input  drrip_pkg::t_status i_status,
    output drrip_pkg::t_cmd    o_cmd
);
    import drrip_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_Q_RD  = 8'b0000_0100,
        ST_Q_EXE = 8'b0000_1000,
        ST_U_RD  = 8'b0001_0000,
        ST_U_EXE = 8'b0010_0000,
        ST_T_RD  = 8'b0100_0000,
        ST_T_WR  = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [SET_W-1:0] r_sweep, n_sweep;
    logic             sweep_last;
    logic             accept;

    assign sweep_last = (r_sweep == SET_W'(SETS - 1));
    assign o_ready    = (r_state == ST_IDLE);
    assign accept     = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        o_cmd   = '0;
        o_cmd.sweep_addr = r_sweep;
        o_cmd.op = OP_CLEAR;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.wr_rrpv = 1'b1;
                o_cmd.wr_dead = 1'b1;
                o_cmd.wr_strm = 1'b1;
                n_sweep = r_sweep + 1'b1;
                if (sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_cmd.load = accept;
                if (accept) begin
                    unique case (t_kind'(i_kind))
                        KIND_QUERY:  n_state = ST_Q_RD;
                        KIND_UPDATE: n_state = ST_U_RD;
                        KIND_TICK: begin
                            n_state = ST_T_RD;
                            n_sweep = '0;
                        end
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_Q_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_Q_EXE;
            end
            ST_Q_EXE: begin
                // hold until the output register can take the result
                o_cmd.op       = OP_QUERY;
                o_cmd.out_load = i_status.out_free;
                o_cmd.wr_rrpv  = i_status.out_free;
                if (i_status.out_free) n_state = ST_IDLE;
            end
            ST_U_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_U_EXE;
            end
            ST_U_EXE: begin
                o_cmd.op      = OP_UPDATE;
                o_cmd.wr_rrpv = 1'b1;
                o_cmd.wr_dead = 1'b1;
                o_cmd.wr_strm = 1'b1;
                n_state = ST_IDLE;
            end
            ST_T_RD: begin
                o_cmd.sweep = 1'b1;
                o_cmd.rd    = 1'b1;
                n_state     = ST_T_WR;
            end
            ST_T_WR: begin
                o_cmd.sweep   = 1'b1;
                o_cmd.op      = OP_TICK;
                o_cmd.wr_dead = 1'b1;
                n_sweep = r_sweep + 1'b1;
                n_state = sweep_last ? ST_IDLE : ST_T_RD;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
        end
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded while output register busy");

    a_tick_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_T_WR) |-> ($past(r_state) == ST_T_RD))
        else $error("decay write without preceding read");

    a_upd_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U_EXE) |=> (r_state == ST_IDLE))
        else $error("update did not return to idle");

endmodule

[rtl/core/drrip_dp.sv]
// ----------------------------------------------------------------------------
// drrip_dp
// Datapath: per-set line stores, stream detector, victim selection, dueling
// selector, LFSR and the result register.
// ----------------------------------------------------------------------------
module drrip_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  drrip_pkg::t_cmd               i_cmd,
    output drrip_pkg::t_status            o_status,
    input  logic [drrip_pkg::SET_W-1:0]   i_set_index,
    input  logic [drrip_pkg::WAY_W-1:0]   i_way_index,
    input  logic [drrip_pkg::WAYS-1:0]    i_valid_mask,
    input  logic [drrip_pkg::ADDR_W-1:0]  i_address,
    input  logic                          i_hit,
    input  logic                          i_cfg_valid,
    input  logic [drrip_pkg::SEED_W-1:0]  i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [drrip_pkg::WAY_W-1:0]   o_victim_way,
    output logic [1:0]                    o_victim_reason
);
    import drrip_pkg::*;

    localparam int RROW_W = WAYS * RRPV_W;
    localparam int DROW_W = WAYS * DEAD_W;

    function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        s = v >> 1;
        if (v[0]) s = s ^ LFSR_TAPS;
        return s;
    endfunction

    logic [RROW_W-1:0] rrpv_mem [SETS];
    logic [DROW_W-1:0] dead_mem [SETS];
    logic [STRM_W-1:0] strm_mem [SETS];

    logic [SET_W-1:0]  r_set;
    logic [WAY_W-1:0]  r_way;
    logic [WAYS-1:0]   r_mask;
    logic [ADDR_W-1:0] r_addr;
    logic              r_hit;
    logic [RROW_W-1:0] r_rrpv_q;
    logic [DROW_W-1:0] r_dead_q;
    logic [STRM_W-1:0] r_strm_q;
    logic [SEL_W-1:0]  r_sel;
    logic [SEED_W-1:0] r_lfsr;
    logic              r_out_valid;
    logic [WAY_W-1:0]  r_out_way;
    logic [1:0]        r_out_reason;

    logic [SET_W-1:0]  mem_addr;
    logic              inv_hit, dead_hit;
    logic [WAY_W-1:0]  inv_way, dead_way, age_way, q_way;
    logic [1:0]        q_reason;
    logic [RRPV_W-1:0] top;
    logic [RROW_W-1:0] aged_row, upd_rrow, rrow_wd;
    logic [DROW_W-1:0] upd_drow, tick_drow, drow_wd;
    logic [STRM_W-1:0] upd_srow, srow_wd;
    logic              seen;
    logic [CONF_W-1:0] conf, n_conf;
    logic [STRIDE_W-1:0] last_stride, stride;
    logic [ADDR_W-1:0] prev_addr;
    logic              same, streaming, srrip_ldr, brrip_ldr, use_bim, upd_exec;
    logic [SEED_W-1:0] lfsr_nx;
    logic [RRPV_W-1:0] bim_depth, depth, new_rrpv;

    assign mem_addr = i_cmd.sweep ? i_cmd.sweep_addr : r_set;
    assign o_status.out_free = !r_out_valid || i_ready;

    // capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set  <= i_set_index;
            r_way  <= i_way_index;
            r_mask <= i_valid_mask;
            r_addr <= i_address;
            r_hit  <= i_hit;
        end
    end

    // victim selection over the registered set rows
    always_comb begin
        inv_hit  = 1'b0;
        inv_way  = '0;
        dead_hit = 1'b0;
        dead_way = '0;
        top      = '0;
        age_way  = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!r_mask[i]) begin
                inv_hit = 1'b1;
                inv_way = WAY_W'(i);
            end
            if (r_dead_q[i*DEAD_W +: DEAD_W] == '0) begin
                dead_hit = 1'b1;
                dead_way = WAY_W'(i);
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            if (r_rrpv_q[i*RRPV_W +: RRPV_W] > top) top = r_rrpv_q[i*RRPV_W +: RRPV_W];
        end
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_rrpv_q[i*RRPV_W +: RRPV_W] == top) age_way = WAY_W'(i);
        end
        for (int i = 0; i < WAYS; i++) begin
            aged_row[i*RRPV_W +: RRPV_W] = r_rrpv_q[i*RRPV_W +: RRPV_W] + (RRPV_TOP - top);
        end
        if (inv_hit) begin
            q_way = inv_way;
            q_reason = REASON_INVALID;
        end else if (dead_hit) begin
            q_way = dead_way;
            q_reason = REASON_DEAD;
        end else begin
            q_way = age_way;
            q_reason = REASON_RRIP;
        end
    end

    // stream detector and insertion depth
    assign {seen, conf, last_stride, prev_addr} = r_strm_q;
    assign stride    = {1'b0, r_addr} - {1'b0, prev_addr};
    assign same      = (stride == last_stride) && (stride != '0);
    assign srrip_ldr = (r_set < SET_W'(LEADER_SETS));
    assign brrip_ldr = !srrip_ldr && (r_set < SET_W'(2 * LEADER_SETS));
    assign lfsr_nx   = lfsr_next(r_lfsr);
    assign bim_depth = (lfsr_nx[BIM_W-1:0] == '0) ? RRPV_TOP - 1'b1 : RRPV_TOP;

    always_comb begin
        n_conf = conf;
        if (seen) begin
            if (same) begin
                if (conf < CONF_TOP) n_conf = conf + 1'b1;
            end else if (conf != '0) begin
                n_conf = conf - 1'b1;
            end
        end
        streaming = seen && (n_conf >= CONF_STREAM);
        use_bim   = !r_hit && !streaming && !srrip_ldr && (brrip_ldr || (r_sel < SEL_MID));
        if (streaming)                depth = RRPV_TOP;
        else if (srrip_ldr)           depth = RRPV_TOP - 1'b1;
        else if (brrip_ldr)           depth = bim_depth;
        else if (r_sel >= SEL_MID)    depth = RRPV_TOP - 1'b1;
        else                          depth = bim_depth;
        new_rrpv = r_hit ? '0 : depth;
        for (int i = 0; i < WAYS; i++) begin
            upd_rrow[i*RRPV_W +: RRPV_W] = (WAY_W'(i) == r_way) ? new_rrpv
                                           : r_rrpv_q[i*RRPV_W +: RRPV_W];
            upd_drow[i*DEAD_W +: DEAD_W] = (WAY_W'(i) == r_way) ? DEAD_FULL
                                           : r_dead_q[i*DEAD_W +: DEAD_W];
            tick_drow[i*DEAD_W +: DEAD_W] = (r_dead_q[i*DEAD_W +: DEAD_W] != '0)
                ? r_dead_q[i*DEAD_W +: DEAD_W] - 1'b1 : r_dead_q[i*DEAD_W +: DEAD_W];
        end
        upd_srow = {1'b1, n_conf, stride, r_addr};
    end

    // select write data by operation
    always_comb begin
        rrow_wd = '0;
        drow_wd = '0;
        srow_wd = '0;
        case (i_cmd.op)
            OP_QUERY:  rrow_wd = aged_row;
            OP_UPDATE: begin
                rrow_wd = upd_rrow;
                drow_wd = upd_drow;
                srow_wd = upd_srow;
            end
            OP_TICK:   drow_wd = tick_drow;
            default:   ;
        endcase
    end

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_rrpv && ((i_cmd.op != OP_QUERY) || (q_reason == REASON_RRIP)))
            rrpv_mem[mem_addr] <= rrow_wd;
        if (i_cmd.rd) r_rrpv_q <= rrpv_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_dead) dead_mem[mem_addr] <= drow_wd;
        if (i_cmd.rd) r_dead_q <= dead_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_strm) strm_mem[mem_addr] <= srow_wd;
        if (i_cmd.rd) r_strm_q <= strm_mem[mem_addr];
    end

    // dueling selector and LFSR
    assign upd_exec = (i_cmd.op == OP_UPDATE) && i_cmd.wr_strm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= SEL_MID;
            r_lfsr <= SEED_RESET;
        end else begin
            if (upd_exec && r_hit) begin
                if (srrip_ldr && (r_sel != SEL_TOP)) r_sel <= r_sel + 1'b1;
                if (brrip_ldr && (r_sel != '0))      r_sel <= r_sel - 1'b1;
            end
            if (i_cfg_valid)
                r_lfsr <= (i_cfg_data == '0) ? SEED_W'(1) : i_cfg_data;
            else if (upd_exec && use_bim)
                r_lfsr <= lfsr_nx;
        end
    end

    // result register: drop on transfer, load on query completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_way    <= q_way;
            r_out_reason <= q_reason;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_victim_way    = r_out_way;
    assign o_victim_reason = r_out_reason;

endmodule

[rtl/core/drrip_stream_dead_block_replacement.sv]
// ----------------------------------------------------------------------------
// drrip_stream_dead_block_replacement
// Top level of the DRRIP replacement engine with stream and dead-line hints.
// ----------------------------------------------------------------------------
// After reset the engine clears all per-set stores, one set per cycle, with
// the input not ready; configuration writes are taken at any time. A victim
// query or an update passes through idle, row read and execute states, since
// each is a read-modify-write of the set's rows in single-port stores; a query
// waits longer only while its result register is still full. A decay tick
// sweeps every set with a read and then a write of each set. Kind 3 is
// accepted and gives no result.
module drrip_stream_dead_block_replacement (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic [drrip_pkg::SET_W-1:0]   i_set_index,
    input  logic [drrip_pkg::WAY_W-1:0]   i_way_index,
    input  logic [drrip_pkg::WAYS-1:0]    i_valid_mask,
    input  logic [drrip_pkg::ADDR_W-1:0]  i_address,
    input  logic                          i_hit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [drrip_pkg::WAY_W-1:0]   o_victim_way,
    output logic [1:0]                    o_victim_reason,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [drrip_pkg::SEED_W-1:0]  i_cfg_data
);
    import drrip_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    drrip_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_kind   (i_kind),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    drrip_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_set_index     (i_set_index),
        .i_way_index     (i_way_index),
        .i_valid_mask    (i_valid_mask),
        .i_address       (i_address),
        .i_hit           (i_hit),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_victim_way    (o_victim_way),
        .o_victim_reason (o_victim_reason)
    );

endmodule

[test/drrip_stream_dead_block_replacement_tb.sv]
// ----------------------------------------------------------------------------
// drrip_stream_dead_block_replacement_tb
// Drives victim queries, updates, decay ticks and unused-kind items through the
// replacement engine with random idling on both channels, reseeds the LFSR
// between phases, and checks every victim result against a local predictor.
// ----------------------------------------------------------------------------
module drrip_stream_dead_block_replacement_tb;
    import drrip_pkg::*;

    typedef struct packed {
        t_kind             kind;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way_index;
        logic [WAYS-1:0]   valid_mask;
        logic [ADDR_W-1:0] address;
        logic              hit;
    } t_access;

    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic [1:0]       reason;
    } t_victim;

    localparam int LIMIT_CYCLES = 3000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_kind;
    logic [SET_W-1:0]    i_set_index;
    logic [WAY_W-1:0]    i_way_index;
    logic [WAYS-1:0]     i_valid_mask;
    logic [ADDR_W-1:0]   i_address;
    logic                i_hit;
    logic                o_valid;
    logic                i_ready;
    logic [WAY_W-1:0]    o_victim_way;
    logic [1:0]          o_victim_reason;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [SEED_W-1:0]   i_cfg_data;

    // predictor state
    logic [RRPV_W-1:0]   rrpv_mem [SETS*WAYS];
    logic [DEAD_W-1:0]   dead_mem [SETS*WAYS];
    logic [ADDR_W-1:0]   prev_addr_mem [SETS];
    logic [63:0]         last_stride_mem [SETS];
    logic [CONF_W-1:0]   conf_mem [SETS];
    logic                seen_mem [SETS];
    logic [SEL_W-1:0]    duel_sel;
    logic [SEED_W-1:0]   lfsr;

    t_access pending_q [$];
    t_victim victim_q [$];
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_recv;
    int      hold_cycles;
    int      fail_count;
    longint  cycle_count;

    drrip_stream_dead_block_replacement u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [RRPV_W-1:0] bimodal_depth();
        logic lsb;
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ LFSR_TAPS;
        return (lfsr[BIM_W-1:0] == '0) ? RRPV_TOP - 1'b1 : RRPV_TOP;
    endfunction

    // Compute the effect of one accepted transfer; queue the victim if any.
    function automatic void predict_access(t_access a);
        int          base;
        int          s;
        logic [63:0] stride;
        logic [RRPV_W-1:0] top;
        logic [RRPV_W-1:0] depth;
        bit          streaming;
        bit          srrip_lead;
        bit          brrip_lead;
        t_victim     v;
        s    = int'(a.set_index);
        base = s * WAYS;
        case (a.kind)
            KIND_QUERY: begin
                for (int i = 0; i < WAYS; i++) begin
                    if (!a.valid_mask[i]) begin
                        v.way = WAY_W'(i); v.reason = REASON_INVALID;
                        victim_q.push_back(v);
                        return;
                    end
                end
                for (int i = 0; i < WAYS; i++) begin
                    if (dead_mem[base+i] == 0) begin
                        v.way = WAY_W'(i); v.reason = REASON_DEAD;
                        victim_q.push_back(v);
                        return;
                    end
                end
                top = 0;
                for (int i = 0; i < WAYS; i++) if (rrpv_mem[base+i] > top) top = rrpv_mem[base+i];
                for (int i = 0; i < WAYS; i++) rrpv_mem[base+i] += RRPV_TOP - top;
                v.way = '0; v.reason = REASON_RRIP;
                for (int i = WAYS - 1; i >= 0; i--)
                    if (rrpv_mem[base+i] == RRPV_TOP) v.way = WAY_W'(i);
                victim_q.push_back(v);
            end
            KIND_UPDATE: begin
                // stride detector, 64-bit wrap
                stride = {16'd0, a.address} - {16'd0, prev_addr_mem[s]};
                streaming = 0;
                if (seen_mem[s]) begin
                    if (stride == last_stride_mem[s] && stride != 0) begin
                        if (conf_mem[s] < CONF_TOP) conf_mem[s]++;
                    end else if (conf_mem[s] > 0) begin
                        conf_mem[s]--;
                    end
                    streaming = conf_mem[s] >= CONF_STREAM;
                end
                last_stride_mem[s] = stride;
                prev_addr_mem[s]   = a.address;
                seen_mem[s]        = 1;
                srrip_lead = s < LEADER_SETS;
                brrip_lead = s >= LEADER_SETS && s < 2 * LEADER_SETS;
                if (a.hit) begin
                    rrpv_mem[base+a.way_index] = 0;
                    dead_mem[base+a.way_index] = DEAD_FULL;
                    if (srrip_lead && duel_sel < SEL_TOP) duel_sel++;
                    if (brrip_lead && duel_sel > 0) duel_sel--;
                    return;
                end
                if (streaming) depth = RRPV_TOP;
                else if (srrip_lead) depth = RRPV_TOP - 1'b1;
                else if (brrip_lead) depth = bimodal_depth();
                else if (duel_sel >= SEL_MID) depth = RRPV_TOP - 1'b1;
                else depth = bimodal_depth();
                rrpv_mem[base+a.way_index] = depth;
                dead_mem[base+a.way_index] = DEAD_FULL;
            end
            KIND_TICK: begin
                for (int i = 0; i < SETS * WAYS; i++) if (dead_mem[i] > 0) dead_mem[i]--;
            end
            default: ;
        endcase
    endfunction

    // Pick a random access; sets and addresses lean on a few hot sets and strides.
    function automatic t_access rand_access(int tick_pct);
        t_access a;
        int      r;
        r = $urandom_range(99);
        if (r < tick_pct) a.kind = KIND_TICK;
        else if (r < tick_pct + 2) a.kind = KIND_NONE;
        else if (r < 55) a.kind = KIND_QUERY;
        else a.kind = KIND_UPDATE;
        case ($urandom_range(3))
            0: a.set_index = SET_W'($urandom_range(2 * LEADER_SETS - 1));
            1: a.set_index = SET_W'($urandom_range(7));
            2: a.set_index = SET_W'(LEADER_SETS + $urandom_range(7));
            default: a.set_index = SET_W'($urandom);
        endcase
        a.way_index = WAY_W'($urandom);
        case ($urandom_range(3))
            0: a.valid_mask = WAYS'($urandom);
            default: a.valid_mask = '1;
        endcase
        a.address = ADDR_W'({$urandom, $urandom});
        if ($urandom_range(1)) begin
            a.address = prev_addr_mem[a.set_index] + ADDR_W'(48'h40 * $urandom_range(1, 2));
        end
        a.hit = $urandom_range(2) == 0;
        return a;
    endfunction

    // Drive the input channel from the pending queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_access a;
                a = pending_q.pop_front();
                i_valid      <= 1'b1;
                i_kind       <= a.kind;
                i_set_index  <= a.set_index;
                i_way_index  <= a.way_index;
                i_valid_mask <= a.valid_mask;
                i_address    <= a.address;
                i_hit        <= a.hit;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Predict on every input transfer; check every output transfer.
    always @(posedge i_clk) begin
        t_access a;
        t_victim v;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                a = '{t_kind'(i_kind), i_set_index, i_way_index, i_valid_mask, i_address, i_hit};
                predict_access(a);
            end
            if (o_valid && i_ready) begin
                if (victim_q.size() == 0) begin
                    $display("%0t: unexpected victim way %0d reason %0d", $time,
                             o_victim_way, o_victim_reason);
                    fail_count++;
                end else begin
                    v = victim_q.pop_front();
                    if (o_victim_way !== v.way || o_victim_reason !== v.reason) begin
                        $display("%0t: victim mismatch expected way %0d reason %0d, got way %0d reason %0d",
                                 $time, v.way, v.reason, o_victim_way, o_victim_reason);
                        fail_count++;
                    end
                end
            end
            i_ready <= !hold_recv && $urandom_range(99) >= recv_stall_pct;
        end
    end

    // Long receiver hold-off, counted on its own.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            hold_recv   <= 1'b1;
        end else begin
            hold_recv   <= 1'b0;
        end
    end

    // End the run at a generous cycle limit.
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sample between edges so the driver's updates of this cycle are settled.
    task automatic drain();
        while (pending_q.size() > 0 || i_valid || victim_q.size() > 0) @(negedge i_clk);
        repeat (5000) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [SEED_W-1:0] seed);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        lfsr = (seed == 0) ? 16'd1 : seed;
    endtask

    task automatic run_phase(int n, int idle, int stall, int tick_pct);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) pending_q.push_back(rand_access(tick_pct));
        drain();
    endtask

    initial begin
        t_access a;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0; i_cfg_valid = 1'b0;
        i_cfg_data = '0; i_kind = '0; i_set_index = '0; i_way_index = '0;
        i_valid_mask = '0; i_address = '0; i_hit = 1'b0;
        hold_recv = 0; hold_cycles = 0; fail_count = 0; cycle_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        foreach (rrpv_mem[i]) begin rrpv_mem[i] = 0; dead_mem[i] = 0; end
        foreach (seen_mem[i]) begin
            seen_mem[i] = 0; prev_addr_mem[i] = 0; last_stride_mem[i] = 0; conf_mem[i] = 0;
        end
        duel_sel = SEL_MID;
        lfsr     = SEED_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every kind, streaming set, aging, unused kind
        a = '{KIND_QUERY, '0, '0, '1, '0, 1'b0};           pending_q.push_back(a);
        a = '{KIND_QUERY, '1, '1, 16'h8000, '1, 1'b1};     pending_q.push_back(a);
        a = '{KIND_QUERY, 11'd5, '0, 16'h7FFF, '0, 1'b0};  pending_q.push_back(a);
        for (int w = 0; w < WAYS; w++) begin
            a = '{KIND_UPDATE, 11'd200, WAY_W'(w), '1, ADDR_W'(w * 64), 1'b0};
            pending_q.push_back(a);
        end
        a = '{KIND_QUERY, 11'd200, '0, '1, '0, 1'b0};      pending_q.push_back(a);
        a = '{KIND_UPDATE, 11'd3, 4'd7, '1, '1, 1'b1};      pending_q.push_back(a);
        a = '{KIND_UPDATE, 11'd70, 4'd2, '1, '0, 1'b1};     pending_q.push_back(a);
        a = '{KIND_NONE, '1, '1, '1, '1, 1'b1};             pending_q.push_back(a);
        a = '{KIND_TICK, '0, '0, '0, '0, 1'b0};             pending_q.push_back(a);
        a = '{KIND_QUERY, 11'd200, '0, '1, '0, 1'b0};      pending_q.push_back(a);
        drain();

        run_phase(450, 0, 0, 1);
        write_seed(16'd1);
        run_phase(450, 76, 0, 1);
        write_seed(16'hFFFF);
        run_phase(450, 0, 76, 1);
        write_seed(16'd0);
        run_phase(300, 23, 23, 1);

        // receiver holds off while queries keep coming
        write_seed(16'h5A5A);
        hold_cycles = 400;
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (60) begin
            a = rand_access(0); a.kind = KIND_QUERY; pending_q.push_back(a);
        end
        drain();
        run_phase(200, 50, 50, 0);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/drrip_pkg.sv
rtl/core/drrip_ctrl.sv
rtl/core/drrip_dp.sv
rtl/core/drrip_stream_dead_block_replacement.sv
test/drrip_stream_dead_block_replacement_tb.sv
